>>> sv/invn_pkg.sv
package invn_pkg;

    // probability format
    localparam int PROB_FRAC_BITS = 48;
    localparam int TD_IN_W        = ((PROB_FRAC_BITS + 7) / 8) * 8;
    localparam logic [63:0] PROB_ONE = 64'd1 << PROB_FRAC_BITS;
    localparam logic [63:0] QMIN_RAW = PROB_ONE / 64'd1000000000000;
    localparam logic [63:0] QMIN_64  = (QMIN_RAW == 64'd0) ? 64'd1 : QMIN_RAW;
    localparam logic [63:0] QMAX_64  = PROB_ONE - 64'd1 - QMIN_64;
    localparam logic [63:0] HALF_64  = PROB_ONE >> 1;

    // log2 and scaling
    localparam int E_W       = $clog2(PROB_FRAC_BITS);
    localparam int FRAC_W    = 30;
    localparam int X_W       = FRAC_W + 1;
    localparam int LOG_STEPS = FRAC_W;
    localparam int LV_W      = $clog2(PROB_FRAC_BITS + 1) + FRAC_W;
    localparam int LO_W      = LV_W / 2;
    localparam int HI_W      = LV_W - LO_W;
    localparam int COEF_W    = 32;
    localparam int S_W       = LV_W + 1;

    // square root and polynomial
    localparam int RT_W  = (S_W + 26 + 1) / 2;
    localparam int V_W   = 2 * RT_W;
    localparam int T2_W  = 2 * RT_W - 28;
    localparam int T3_W  = T2_W + RT_W - 28;
    localparam int A1_W  = COEF_W + RT_W - 28;
    localparam int A2_W  = COEF_W + T2_W - 28;
    localparam int A3_W  = COEF_W + T3_W - 28;
    localparam int NUM_W = A2_W + 2;
    localparam int DEN_W = A3_W + 2;
    localparam int N_W   = NUM_W + 28;
    localparam int Q_W   = 30;

    // result format
    localparam int Z_W      = 31;
    localparam int TD_OUT_W = ((Z_W + 7) / 8) * 8;
    localparam int MAG_W    = RT_W + 2;

    // coefficients, rounded to nearest in Q30
    localparam logic [63:0] TWO_LN2_64 =
        ((64'd13862943611 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C0_64 = ((64'd2515516698 << 30) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] C1_64 = ((64'd802853 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] C2_64 = ((64'd10328 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D1_64 = ((64'd1432788 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D2_64 = ((64'd189269 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D3_64 = ((64'd1308 << 30) + 64'd500000) / 64'd1000000;

    localparam logic [COEF_W-1:0] TWO_LN2 = TWO_LN2_64[COEF_W-1:0];
    localparam logic [COEF_W-1:0] COEF_C0 = C0_64[COEF_W-1:0];
    localparam logic [COEF_W-1:0] COEF_C1 = C1_64[COEF_W-1:0];
    localparam logic [COEF_W-1:0] COEF_C2 = C2_64[COEF_W-1:0];
    localparam logic [COEF_W-1:0] COEF_D1 = D1_64[COEF_W-1:0];
    localparam logic [COEF_W-1:0] COEF_D2 = D2_64[COEF_W-1:0];
    localparam logic [COEF_W-1:0] COEF_D3 = D3_64[COEF_W-1:0];

    // data that rides along a pipelined unit
    typedef struct packed {
        logic            upper;
        logic [RT_W-1:0] t;
    } t_side;

endpackage

>>> sv/invn_sqrt.sv
module invn_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [invn_pkg::V_W-1:0]   i_v,
    input  invn_pkg::t_side            i_side,
    output logic                       o_vld,
    output logic [invn_pkg::RT_W-1:0]  o_root,
    output invn_pkg::t_side            o_side
);
    import invn_pkg::*;

    localparam int REM_W = RT_W + 3;

    logic              r_vld  [RT_W];
    logic [REM_W-1:0]  r_rem  [RT_W];
    logic [RT_W-1:0]   r_root [RT_W];
    logic [V_W-1:0]    r_v    [RT_W];
    t_side             r_side [RT_W];

    // one root bit per stage, two radicand bits consumed
    for (genvar k = 0; k < RT_W; k++) begin : g_stage
        logic              p_vld;
        logic [REM_W-1:0]  p_rem;
        logic [RT_W-1:0]   p_root;
        logic [V_W-1:0]    p_v;
        t_side             p_side;
        logic [REM_W-1:0]  n_shift;
        logic [REM_W-1:0]  n_trial;
        logic              n_take;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_v    = i_v;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_v    = r_v[k-1];
            assign p_side = r_side[k-1];
        end

        assign n_shift = {p_rem[REM_W-3:0], p_v[2*(RT_W-1-k)+1 -: 2]};
        assign n_trial = {1'b0, p_root, 2'b01};
        assign n_take  = (n_shift >= n_trial);

        // advance the stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_take ? (n_shift - n_trial) : n_shift;
                r_root[k] <= {p_root[RT_W-2:0], n_take};
                r_v[k]    <= p_v;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[RT_W-1];
    assign o_root = r_root[RT_W-1];
    assign o_side = r_side[RT_W-1];

endmodule

>>> sv/invn_div.sv
module invn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [invn_pkg::NUM_W-1:0]  i_num,
    input  logic [invn_pkg::DEN_W-1:0]  i_den,
    input  invn_pkg::t_side             i_side,
    output logic                        o_vld,
    output logic [invn_pkg::Q_W-1:0]    o_quo,
    output invn_pkg::t_side             o_side
);
    import invn_pkg::*;

    localparam int REM_W = DEN_W + 1;

    logic              r_pvld;
    logic [N_W-1:0]    r_pn;
    logic [DEN_W-1:0]  r_pden;
    t_side             r_pside;

    logic              r_vld  [Q_W];
    logic [REM_W-1:0]  r_rem  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [N_W-1:0]    r_n    [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    t_side             r_side [Q_W];

    // form the rounded dividend num * 2^27 + den / 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (i_en) begin
            r_pvld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pn    <= {1'b0, i_num, 27'b0} + {{(N_W-DEN_W+1){1'b0}}, i_den[DEN_W-1:1]};
            r_pden  <= i_den;
            r_pside <= i_side;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic              p_vld;
        logic [REM_W-1:0]  p_rem;
        logic [Q_W-1:0]    p_quo;
        logic [N_W-1:0]    p_n;
        logic [DEN_W-1:0]  p_den;
        t_side             p_side;
        logic [REM_W-1:0]  n_shift;
        logic              n_take;

        if (k == 0) begin : g_first
            assign p_vld  = r_pvld;
            assign p_rem  = {{(REM_W-(N_W-Q_W)){1'b0}}, r_pn[N_W-1:Q_W]};
            assign p_quo  = '0;
            assign p_n    = r_pn;
            assign p_den  = r_pden;
            assign p_side = r_pside;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_n    = r_n[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        assign n_shift = {p_rem[REM_W-2:0], p_n[Q_W-1-k]};
        assign n_take  = (n_shift >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_take ? (n_shift - {1'b0, p_den}) : n_shift;
                r_quo[k]  <= {p_quo[Q_W-2:0], n_take};
                r_n[k]    <= p_n;
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_quo  = r_quo[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

>>> sv/inverse_normal_tail_quantile.sv
// Inverse upper-tail normal quantile, Abramowitz-Stegun 26.2.23, fixed point.
// Throughput: one request per cycle; the pipeline stalls as a whole when
// the output register is full and not taken.
// Reset: synchronous, active low; clears stage valid bits only.
module inverse_normal_tail_quantile (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [invn_pkg::TD_IN_W-1:0]   i_s_tdata,  // [47:0] q
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [invn_pkg::TD_OUT_W-1:0]  o_m_tdata   // [30:0] z, [31] zero
);
    import invn_pkg::*;

    localparam logic [PROB_FRAC_BITS-1:0] QMIN = QMIN_64[PROB_FRAC_BITS-1:0];
    localparam logic [PROB_FRAC_BITS-1:0] QMAX = QMAX_64[PROB_FRAC_BITS-1:0];
    localparam logic [PROB_FRAC_BITS-1:0] HALF = HALF_64[PROB_FRAC_BITS-1:0];
    localparam logic [PROB_FRAC_BITS:0]   ONE  = PROB_ONE[PROB_FRAC_BITS:0];
    localparam logic [MAG_W-1:0] ZMAX = MAG_W'(64'd1073741823);
    localparam logic [MAG_W-1:0] ZMIN = ~ZMAX;

    logic adv;

    // whole pipeline advances unless the output register is held
    assign adv        = !o_m_tvalid || i_m_tready;
    assign o_s_tready = adv;

    // ---------------- clamp and fold ----------------
    logic                      r_v1, r_u1;
    logic [PROB_FRAC_BITS-1:0] r_p1;
    logic [PROB_FRAC_BITS-1:0] n_q;
    logic [PROB_FRAC_BITS:0]   n_flip;

    always_comb begin
        n_q = i_s_tdata[PROB_FRAC_BITS-1:0];
        if (n_q < QMIN) begin
            n_q = QMIN;
        end
        if (n_q > QMAX) begin
            n_q = QMAX;
        end
        n_flip = ONE - {1'b0, n_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u1 <= (n_q < HALF);
            r_p1 <= (n_q < HALF) ? n_q : n_flip[PROB_FRAC_BITS-1:0];
        end
    end

    // ---------------- leading one ----------------
    logic                      r_v2, r_u2;
    logic [PROB_FRAC_BITS-1:0] r_p2;
    logic [E_W-1:0]            r_e2;
    logic [E_W-1:0]            n_e;

    always_comb begin
        n_e = '0;
        for (int i = 0; i < PROB_FRAC_BITS; i++) begin
            if (r_p1[i]) begin
                n_e = E_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u2 <= r_u1;
            r_p2 <= r_p1;
            r_e2 <= n_e;
        end
    end

    // ---------------- normalize to [1,2) ----------------
    logic                               r_v3, r_u3;
    logic [E_W-1:0]                     r_e3;
    logic [X_W-1:0]                     r_x3;
    logic [PROB_FRAC_BITS+FRAC_W-1:0]   n_wide;

    assign n_wide = {r_p2, {FRAC_W{1'b0}}} >> r_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u3 <= r_u2;
            r_e3 <= r_e2;
            r_x3 <= n_wide[X_W-1:0];
        end
    end

    // ---------------- log2 fraction, one bit per stage ----------------
    logic              r_lv [LOG_STEPS];
    logic              r_lu [LOG_STEPS];
    logic [E_W-1:0]    r_le [LOG_STEPS];
    logic [X_W-1:0]    r_lx [LOG_STEPS];
    logic [FRAC_W-1:0] r_lf [LOG_STEPS];

    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
        logic              p_v, p_u;
        logic [E_W-1:0]    p_e;
        logic [X_W-1:0]    p_x;
        logic [FRAC_W-1:0] p_f;
        logic [2*X_W-1:0]  n_sq;
        logic [X_W:0]      n_y;

        if (k == 0) begin : g_first
            assign p_v = r_v3;
            assign p_u = r_u3;
            assign p_e = r_e3;
            assign p_x = r_x3;
            assign p_f = '0;
        end else begin : g_next
            assign p_v = r_lv[k-1];
            assign p_u = r_lu[k-1];
            assign p_e = r_le[k-1];
            assign p_x = r_lx[k-1];
            assign p_f = r_lf[k-1];
        end

        assign n_sq = p_x * p_x;
        assign n_y  = n_sq[2*X_W-1:FRAC_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv[k] <= 1'b0;
            end else if (adv) begin
                r_lv[k] <= p_v;
            end
        end

        // square, and halve with a fraction bit when it reaches two
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_lu[k] <= p_u;
                r_le[k] <= p_e;
                r_lx[k] <= n_y[X_W] ? n_y[X_W:1] : n_y[X_W-1:0];
                r_lf[k] <= p_f | (FRAC_W'(n_y[X_W]) << (FRAC_W - 1 - k));
            end
        end
    end

    // ---------------- s = L * 2 ln 2 ----------------
    logic              r_va, r_ua;
    logic [LV_W-1:0]   r_lval;
    logic              r_vb, r_ub;
    logic [HI_W+COEF_W-1:0] r_pph;
    logic [LO_W+COEF_W-1:0] r_ppl;
    logic              r_vc, r_uc;
    logic [S_W-1:0]    r_s;
    logic [LV_W-1:0]   n_k;
    logic [LV_W+COEF_W-1:0] n_prod;

    assign n_k    = LV_W'(PROB_FRAC_BITS) - LV_W'(r_le[LOG_STEPS-1]);
    assign n_prod = {r_pph, {LO_W{1'b0}}} + {{HI_W{1'b0}}, r_ppl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (adv) begin
            r_va <= r_lv[LOG_STEPS-1];
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // split the wide product into two partial products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ua   <= r_lu[LOG_STEPS-1];
            r_lval <= (n_k << FRAC_W) - {{(LV_W-FRAC_W){1'b0}}, r_lf[LOG_STEPS-1]};
            r_ub   <= r_ua;
            r_pph  <= r_lval[LV_W-1:LO_W] * TWO_LN2;
            r_ppl  <= r_lval[LO_W-1:0] * TWO_LN2;
            r_uc   <= r_ub;
            r_s    <= n_prod[FRAC_W+S_W-1:FRAC_W];
        end
    end

    // ---------------- t = sqrt(s * 2^26) ----------------
    logic            w_sq_vld;
    logic [RT_W-1:0] w_t;
    t_side           w_sq_side;
    t_side           w_sq_in;
    logic [V_W-1:0]  w_rad;

    assign w_sq_in.upper = r_uc;
    assign w_sq_in.t     = '0;
    assign w_rad         = {{(V_W-S_W-26){1'b0}}, r_s, 26'b0};

    invn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_vc),
        .i_v     (w_rad),
        .i_side  (w_sq_in),
        .o_vld   (w_sq_vld),
        .o_root  (w_t),
        .o_side  (w_sq_side)
    );

    // ---------------- powers of t and coefficient products ----------------
    logic              r_m1v, r_m1u;
    logic [RT_W-1:0]   r_m1t;
    logic [T2_W-1:0]   r_t2;
    logic [A1_W-1:0]   r_c1t, r_d1t;
    logic              r_m2v, r_m2u;
    logic [RT_W-1:0]   r_m2t;
    logic [T3_W-1:0]   r_t3;
    logic [A1_W-1:0]   r_m2c1, r_m2d1;
    logic [A2_W-1:0]   r_c2t2, r_d2t2;
    logic              r_m3v, r_m3u;
    logic [RT_W-1:0]   r_m3t;
    logic [A1_W-1:0]   r_m3c1, r_m3d1;
    logic [A2_W-1:0]   r_m3c2, r_m3d2;
    logic [A3_W-1:0]   r_d3t3;

    logic [2*RT_W-1:0]        n_tt;
    logic [COEF_W+RT_W-1:0]   n_c1, n_d1;
    logic [T2_W+RT_W-1:0]     n_ttt;
    logic [COEF_W+T2_W-1:0]   n_c2, n_d2;
    logic [COEF_W+T3_W-1:0]   n_d3;

    assign n_tt  = w_t * w_t;
    assign n_c1  = COEF_C1 * w_t;
    assign n_d1  = COEF_D1 * w_t;
    assign n_ttt = r_t2 * r_m1t;
    assign n_c2  = COEF_C2 * r_t2;
    assign n_d2  = COEF_D2 * r_t2;
    assign n_d3  = COEF_D3 * r_t3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1v <= 1'b0;
            r_m2v <= 1'b0;
            r_m3v <= 1'b0;
        end else if (adv) begin
            r_m1v <= w_sq_vld;
            r_m2v <= r_m1v;
            r_m3v <= r_m2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1u  <= w_sq_side.upper;
            r_m1t  <= w_t;
            r_t2   <= n_tt[2*RT_W-1:28];
            r_c1t  <= n_c1[COEF_W+RT_W-1:28];
            r_d1t  <= n_d1[COEF_W+RT_W-1:28];
            r_m2u  <= r_m1u;
            r_m2t  <= r_m1t;
            r_t3   <= n_ttt[T2_W+RT_W-1:28];
            r_m2c1 <= r_c1t;
            r_m2d1 <= r_d1t;
            r_c2t2 <= n_c2[COEF_W+T2_W-1:28];
            r_d2t2 <= n_d2[COEF_W+T2_W-1:28];
            r_m3u  <= r_m2u;
            r_m3t  <= r_m2t;
            r_m3c1 <= r_m2c1;
            r_m3d1 <= r_m2d1;
            r_m3c2 <= r_c2t2;
            r_m3d2 <= r_d2t2;
            r_d3t3 <= n_d3[COEF_W+T3_W-1:28];
        end
    end

    // ---------------- numerator and denominator ----------------
    logic              r_sv;
    t_side             r_sside;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (adv) begin
            r_sv <= r_m3v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sside.upper <= r_m3u;
            r_sside.t     <= r_m3t;
            r_num <= NUM_W'(COEF_C0) + NUM_W'(r_m3c1) + NUM_W'(r_m3c2);
            r_den <= (DEN_W'(1) << FRAC_W) + DEN_W'(r_m3d1) + DEN_W'(r_m3d2)
                   + DEN_W'(r_d3t3);
        end
    end

    // ---------------- ratio ----------------
    logic           w_dv_vld;
    logic [Q_W-1:0] w_ratio;
    t_side          w_dv_side;

    invn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_sv),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_sside),
        .o_vld   (w_dv_vld),
        .o_quo   (w_ratio),
        .o_side  (w_dv_side)
    );

    // ---------------- sign, saturate, output register ----------------
    logic             r_ov;
    logic [Z_W-1:0]   r_z;
    logic [RT_W:0]    n_tinc;
    logic [MAG_W-1:0] n_mag;
    logic [MAG_W-1:0] n_sgn;
    logic [Z_W-1:0]   n_z;

    always_comb begin
        n_tinc = {1'b0, w_dv_side.t} + (RT_W+1)'(1);
        n_mag  = {2'b00, n_tinc[RT_W:1]} - {{(MAG_W-Q_W){1'b0}}, w_ratio};
        n_sgn  = w_dv_side.upper ? n_mag : (~n_mag + MAG_W'(1));
        priority if ($signed(n_sgn) > $signed(ZMAX)) begin
            n_z = ZMAX[Z_W-1:0];
        end else if ($signed(n_sgn) < $signed(ZMIN)) begin
            n_z = ZMIN[Z_W-1:0];
        end else begin
            n_z = n_sgn[Z_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_z <= n_z;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(TD_OUT_W-Z_W){1'b0}}, r_z};

endmodule

>>> sv/invn_chk.sv
module invn_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [invn_pkg::TD_OUT_W-1:0]  o_m_tdata
);
    import invn_pkg::*;

    // held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a stalled output blocks new requests
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while output stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // clamped inputs keep the deviate below seven and a half in magnitude, pad bits zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[Z_W-1:0]) < 31'sd1006632960)
                       && ($signed(o_m_tdata[Z_W-1:0]) > -31'sd1006632960)
                       && (o_m_tdata[TD_OUT_W-1:Z_W] == '0))
        else $error("deviate out of range");

endmodule

bind inverse_normal_tail_quantile invn_chk u_chk (.*);
